[sv/pgf_pkg.sv]
// Shared widths, types and codes for the pairwise gravity force pipeline.
// Used by every module of the block; depends on nothing.
package pgf_pkg;

    localparam int unsigned WORD_W        = 32;
    localparam int unsigned LANES         = 3;
    localparam int unsigned MAG_W         = 33;
    localparam int unsigned S_W           = 66;
    localparam int unsigned K_W           = 128;
    localparam int unsigned KX_W          = 96;
    localparam int unsigned ROOT_W        = 51;
    localparam int unsigned REM_W         = 98;
    localparam int unsigned TRIAL_W       = 102;
    localparam int unsigned D_W           = 117;
    localparam int unsigned NUM_W         = 161;
    localparam int unsigned Q_W           = 64;
    localparam int unsigned FRONT_STAGES  = 7;
    localparam int unsigned PROD_STAGES   = 4;
    localparam int unsigned DIV_STAGES    = Q_W + 1;
    localparam int unsigned IN_W          = 8 * WORD_W;
    localparam int unsigned OUT_W         = LANES * Q_W;
    localparam int unsigned USER_W        = 2;

    localparam logic CFG_GRAVITY   = 1'b0;
    localparam logic CFG_TIME_STEP = 1'b1;

    localparam logic [WORD_W-1:0] GRAVITY_RESET   = 32'd65536;
    localparam logic [15:0]       TIME_STEP_RESET = 16'd1092;

    localparam logic [Q_W-1:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [Q_W-1:0] NEG_MIN = 64'h8000_0000_0000_0000;

    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [2*WORD_W-1:0] t_p64;
    typedef logic [MAG_W-1:0]   t_mag;
    typedef logic [S_W-1:0]     t_s;
    typedef logic [K_W-1:0]     t_k;
    typedef logic [KX_W-1:0]    t_kx;
    typedef logic [ROOT_W-1:0]  t_root;
    typedef logic [REM_W-1:0]   t_rem;
    typedef logic [TRIAL_W-1:0] t_trial;
    typedef logic [D_W-1:0]     t_d;
    typedef logic [D_W:0]       t_dsh;
    typedef logic [NUM_W-1:0]   t_num;
    typedef logic [Q_W-1:0]     t_q;
    typedef logic [58:0]        t_p59;
    typedef logic [64:0]        t_p65;

    // Front-end stage contents; fields fill in as the item moves along.
    typedef struct packed {
        logic [LANES-1:0][MAG_W-1:0] mag;
        logic [LANES-1:0]            neg;
        logic [LANES-1:0][S_W-1:0]   sq;
        t_s                          s;
        t_k                          k;
        t_kx                         kx;
        t_word                       m1;
        t_word                       m2;
        t_word                       g;
        t_word                       ts2;
        logic                        zero;
    } t_fr;

    typedef struct packed {
        logic [LANES-1:0][MAG_W-1:0] mag;
        logic [LANES-1:0]            neg;
        t_s                          s;
        t_k                          k;
        logic                        zero;
    } t_item;

    typedef struct packed {
        t_item it;
        t_root res;
        t_rem  rem;
    } t_sq;

    typedef struct packed {
        logic [LANES-1:0][MAG_W-1:0] mag;
        logic [LANES-1:0]            neg;
        t_s                          s;
        t_root                       r;
        t_k                          k;
        logic                        zero;
        t_d                          d;
        logic [LANES-1:0][NUM_W-1:0] num;
    } t_pr;

    typedef struct packed {
        t_d                        d;
        logic [LANES-1:0][D_W-1:0] rem;
        logic [LANES-1:0][Q_W-1:0] lo;
        logic [LANES-1:0]          big;
        logic [LANES-1:0]          neg;
        logic                      zero;
    } t_dv;

    typedef struct packed {
        logic [LANES-1:0][Q_W-1:0] q;
        logic [LANES-1:0]          big;
        logic [LANES-1:0]          neg;
        logic                      zero;
    } t_res;

endpackage

[sv/pairwise_gravity_force.sv]
// Pairwise gravity force, fixed point. An input transfer passes the front end,
// square root, product and divide stages and the output register to o_m_tvalid.
// Throughput: one pair per cycle while the consumer is ready and the skid is empty.
// A consumer stall that meets a waiting result fills the skid; input is held until it drains.
// Reset (synchronous, active low) clears all valid bits and loads the
// gravity constant and time step with their defaults.
module pairwise_gravity_force (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // first_x, first_y, first_z, first_mass, second_x, second_y, second_z, second_mass
    input  logic [pgf_pkg::IN_W-1:0]      i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // force_x, force_y, force_z
    output logic [pgf_pkg::OUT_W-1:0]     o_m_tdata,
    // coincident, saturated
    output logic [pgf_pkg::USER_W-1:0]    o_m_tuser,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  pgf_pkg::t_word                i_cfg_data
);

    pgf_pkg::t_word r_gravity;
    logic [15:0]    r_time_step;

    logic           w_en;
    logic [pgf_pkg::LANES-1:0][pgf_pkg::WORD_W-1:0] w_first_pos;
    logic [pgf_pkg::LANES-1:0][pgf_pkg::WORD_W-1:0] w_second_pos;

    logic           w_fr_v;
    pgf_pkg::t_item w_fr_item;
    logic           w_rt_v;
    pgf_pkg::t_item w_rt_item;
    pgf_pkg::t_root w_rt_root;
    logic           w_pr_v;
    pgf_pkg::t_pr   w_pr;
    logic           w_pipe_v;
    pgf_pkg::t_res  w_res;

    logic [pgf_pkg::OUT_W-1:0]  w_fin_data;
    logic [pgf_pkg::USER_W-1:0] w_fin_user;
    logic [pgf_pkg::LANES-1:0]  w_sat;

    logic                       r_out_v;
    logic [pgf_pkg::OUT_W-1:0]  r_out_data;
    logic [pgf_pkg::USER_W-1:0] r_out_user;
    logic                       r_skid_v;
    logic [pgf_pkg::OUT_W-1:0]  r_skid_data;
    logic [pgf_pkg::USER_W-1:0] r_skid_user;

    // Configuration.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity   <= pgf_pkg::GRAVITY_RESET;
            r_time_step <= pgf_pkg::TIME_STEP_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pgf_pkg::CFG_GRAVITY:   r_gravity   <= i_cfg_data;
                pgf_pkg::CFG_TIME_STEP: r_time_step <= i_cfg_data[15:0];
                default:                r_gravity   <= r_gravity;
            endcase
        end
    end

    // The whole pipeline moves together and halts only when the skid is full.
    assign w_en       = !r_skid_v;
    assign o_s_tready = w_en;

    always_comb begin
        for (int l = 0; l < pgf_pkg::LANES; l++) begin
            w_first_pos[l]  = i_s_tdata[pgf_pkg::WORD_W*l +: pgf_pkg::WORD_W];
            w_second_pos[l] = i_s_tdata[pgf_pkg::WORD_W*(l+4) +: pgf_pkg::WORD_W];
        end
    end

    pgf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (i_s_tvalid),
        .i_first_pos   (w_first_pos),
        .i_second_pos  (w_second_pos),
        .i_first_mass  (i_s_tdata[127:96]),
        .i_second_mass (i_s_tdata[255:224]),
        .i_gravity     (r_gravity),
        .i_time_step   (r_time_step),
        .o_valid       (w_fr_v),
        .o_item        (w_fr_item)
    );

    pgf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fr_v),
        .i_item  (w_fr_item),
        .o_valid (w_rt_v),
        .o_item  (w_rt_item),
        .o_root  (w_rt_root)
    );

    pgf_prod u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_rt_v),
        .i_item  (w_rt_item),
        .i_root  (w_rt_root),
        .o_valid (w_pr_v),
        .o_prod  (w_pr)
    );

    pgf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_pr_v),
        .i_prod  (w_pr),
        .o_valid (w_pipe_v),
        .o_res   (w_res)
    );

    // Sign and clipping. A negative component may reach -2^63 exactly.
    always_comb begin
        for (int l = 0; l < pgf_pkg::LANES; l++) begin
            if (!w_res.neg[l]) begin
                w_sat[l] = w_res.big[l] || w_res.q[l][pgf_pkg::Q_W-1];
                w_fin_data[pgf_pkg::Q_W*l +: pgf_pkg::Q_W] =
                    w_sat[l] ? pgf_pkg::POS_MAX : w_res.q[l];
            end else begin
                w_sat[l] = w_res.big[l] || (w_res.q[l] > pgf_pkg::NEG_MIN);
                w_fin_data[pgf_pkg::Q_W*l +: pgf_pkg::Q_W] =
                    w_sat[l] ? pgf_pkg::NEG_MIN : (~w_res.q[l] + 1'b1);
            end
            if (w_res.zero) begin
                w_fin_data[pgf_pkg::Q_W*l +: pgf_pkg::Q_W] = '0;
            end
        end
        w_fin_user = {(|w_sat) && !w_res.zero, w_res.zero};
    end

    // Output register with a one-entry skid behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (i_m_tready) begin
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || i_m_tready) begin
            r_out_v <= w_pipe_v;
        end else if (w_pipe_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (i_m_tready) begin
                r_out_data <= r_skid_data;
                r_out_user <= r_skid_user;
            end
        end else if (!r_out_v || i_m_tready) begin
            r_out_data <= w_fin_data;
            r_out_user <= w_fin_user;
        end else begin
            r_skid_data <= w_fin_data;
            r_skid_user <= w_fin_user;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held without an output entry");

    a_skid_fill_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !i_m_tready && w_pipe_v))
        else $error("skid filled without a stalled output");

    a_coincident_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (!o_m_tuser[1] && o_m_tdata == '0))
        else $error("coincident result carries a force or a clip flag");
`endif

endmodule

[sv/pgf_front.sv]
// Front end: separation vector, squared distance and the scale factor
// time_step^2 * G * m1 * m2 built one 32-bit limb per stage. Uses pgf_pkg.
module pgf_front (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_en,
    input  logic                                     i_valid,
    input  logic [pgf_pkg::LANES-1:0][pgf_pkg::WORD_W-1:0] i_first_pos,
    input  logic [pgf_pkg::LANES-1:0][pgf_pkg::WORD_W-1:0] i_second_pos,
    input  pgf_pkg::t_word                           i_first_mass,
    input  pgf_pkg::t_word                           i_second_mass,
    input  pgf_pkg::t_word                           i_gravity,
    input  logic [15:0]                              i_time_step,
    output logic                                     o_valid,
    output pgf_pkg::t_item                           o_item
);

    pgf_pkg::t_fr n_fr [pgf_pkg::FRONT_STAGES];
    pgf_pkg::t_fr r_fr [pgf_pkg::FRONT_STAGES];
    logic [pgf_pkg::FRONT_STAGES-1:0] r_vld;
    logic signed [pgf_pkg::MAG_W-1:0] w_diff [pgf_pkg::LANES];

    always_comb begin
        for (int l = 0; l < pgf_pkg::LANES; l++) begin
            w_diff[l] = $signed({i_second_pos[l][pgf_pkg::WORD_W-1], i_second_pos[l]})
                      - $signed({i_first_pos[l][pgf_pkg::WORD_W-1], i_first_pos[l]});
        end

        n_fr[0] = '0;
        for (int l = 0; l < pgf_pkg::LANES; l++) begin
            n_fr[0].neg[l] = w_diff[l][pgf_pkg::MAG_W-1];
            // The difference lies within +-(2^32 - 1), so its negation never overflows
            // and the magnitude always fits.
            n_fr[0].mag[l] = w_diff[l][pgf_pkg::MAG_W-1] ? pgf_pkg::t_mag'(-w_diff[l])
                                                          : pgf_pkg::t_mag'(w_diff[l]);
        end
        n_fr[0].ts2 = {16'b0, i_time_step} * {16'b0, i_time_step};
        n_fr[0].g   = i_gravity;
        n_fr[0].m1  = i_first_mass;
        n_fr[0].m2  = i_second_mass;

        n_fr[1] = r_fr[0];
        for (int l = 0; l < pgf_pkg::LANES; l++) begin
            n_fr[1].sq[l] = {33'b0, r_fr[0].mag[l]} * {33'b0, r_fr[0].mag[l]};
        end
        n_fr[1].kx = {32'b0, pgf_pkg::t_p64'({32'b0, r_fr[0].ts2} * {32'b0, r_fr[0].g})};

        n_fr[2]   = r_fr[1];
        n_fr[2].s = r_fr[1].sq[0] + r_fr[1].sq[1] + r_fr[1].sq[2];
        n_fr[2].k = {64'b0, pgf_pkg::t_p64'({32'b0, r_fr[1].kx[31:0]} * {32'b0, r_fr[1].m1})};

        n_fr[3]      = r_fr[2];
        n_fr[3].kx   = r_fr[2].k[pgf_pkg::KX_W-1:0]
                     + {pgf_pkg::t_p64'({32'b0, r_fr[2].kx[63:32]} * {32'b0, r_fr[2].m1}),
                        32'b0};
        n_fr[3].zero = (r_fr[2].s == '0);

        n_fr[4]   = r_fr[3];
        n_fr[4].k = {64'b0, pgf_pkg::t_p64'({32'b0, r_fr[3].kx[31:0]} * {32'b0, r_fr[3].m2})};

        n_fr[5]   = r_fr[4];
        n_fr[5].k = r_fr[4].k
                  + {32'b0, pgf_pkg::t_p64'({32'b0, r_fr[4].kx[63:32]} * {32'b0, r_fr[4].m2}),
                     32'b0};

        n_fr[6]   = r_fr[5];
        n_fr[6].k = r_fr[5].k
                  + {pgf_pkg::t_p64'({32'b0, r_fr[5].kx[95:64]} * {32'b0, r_fr[5].m2}), 64'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[pgf_pkg::FRONT_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < pgf_pkg::FRONT_STAGES; j++) begin
                r_fr[j] <= n_fr[j];
            end
        end
    end

    assign o_valid     = r_vld[pgf_pkg::FRONT_STAGES-1];
    assign o_item.mag  = r_fr[pgf_pkg::FRONT_STAGES-1].mag;
    assign o_item.neg  = r_fr[pgf_pkg::FRONT_STAGES-1].neg;
    assign o_item.s    = r_fr[pgf_pkg::FRONT_STAGES-1].s;
    assign o_item.k    = r_fr[pgf_pkg::FRONT_STAGES-1].k;
    assign o_item.zero = r_fr[pgf_pkg::FRONT_STAGES-1].zero;

endmodule

[sv/pgf_sqrt.sv]
// Pipelined integer square root of S * 2^32, one result bit per stage.
// Carries the rest of the item along. Uses pgf_pkg.
module pgf_sqrt (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  pgf_pkg::t_item i_item,
    output logic           o_valid,
    output pgf_pkg::t_item o_item,
    output pgf_pkg::t_root o_root
);

    pgf_pkg::t_sq n_st [pgf_pkg::ROOT_W];
    pgf_pkg::t_sq r_st [pgf_pkg::ROOT_W];
    logic [pgf_pkg::ROOT_W-1:0] r_vld;

    always_comb begin
        pgf_pkg::t_sq    prev;
        pgf_pkg::t_trial trial;
        logic            fit;
        int              b;
        for (int j = 0; j < pgf_pkg::ROOT_W; j++) begin
            b = pgf_pkg::ROOT_W - 1 - j;
            if (j == 0) begin
                prev.it  = i_item;
                prev.res = '0;
                prev.rem = {i_item.s, 32'b0};
            end else begin
                prev = r_st[j-1];
            end
            // The root so far has no bits at or below b, so the OR is the sum
            // 2*res*2^b + 2^(2b) that the remainder must cover.
            trial = (pgf_pkg::t_trial'(prev.res) << (b + 1))
                  | (pgf_pkg::t_trial'(1) << (2 * b));
            fit   = (pgf_pkg::t_trial'(prev.rem) >= trial);
            n_st[j]     = prev;
            n_st[j].rem = fit ? (prev.rem - trial[pgf_pkg::REM_W-1:0]) : prev.rem;
            n_st[j].res = fit ? (prev.res | (pgf_pkg::t_root'(1) << b)) : prev.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[pgf_pkg::ROOT_W-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < pgf_pkg::ROOT_W; j++) begin
                r_st[j] <= n_st[j];
            end
        end
    end

    assign o_valid = r_vld[pgf_pkg::ROOT_W-1];
    assign o_item  = r_st[pgf_pkg::ROOT_W-1].it;
    assign o_root  = r_st[pgf_pkg::ROOT_W-1].res;

endmodule

[sv/pgf_prod.sv]
// Distance cubed S * R and the three numerators K * |dk|, one partial
// product per lane and stage. Uses pgf_pkg.
module pgf_prod (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  pgf_pkg::t_item i_item,
    input  pgf_pkg::t_root i_root,
    output logic           o_valid,
    output pgf_pkg::t_pr   o_prod
);

    pgf_pkg::t_pr n_pr [pgf_pkg::PROD_STAGES];
    pgf_pkg::t_pr r_pr [pgf_pkg::PROD_STAGES];
    logic [pgf_pkg::PROD_STAGES-1:0] r_vld;

    always_comb begin
        pgf_pkg::t_pr prev;

        n_pr[0].mag  = i_item.mag;
        n_pr[0].neg  = i_item.neg;
        n_pr[0].s    = i_item.s;
        n_pr[0].r    = i_root;
        n_pr[0].k    = i_item.k;
        n_pr[0].zero = i_item.zero;
        n_pr[0].d    = pgf_pkg::t_d'(pgf_pkg::t_p59'(i_item.s[32:0])
                                     * pgf_pkg::t_p59'(i_root[25:0]));
        for (int l = 0; l < pgf_pkg::LANES; l++) begin
            n_pr[0].num[l] = pgf_pkg::t_num'(pgf_pkg::t_p65'(i_item.k[31:0])
                                             * pgf_pkg::t_p65'(i_item.mag[l]));
        end

        for (int p = 1; p < pgf_pkg::PROD_STAGES; p++) begin
            prev    = r_pr[p-1];
            n_pr[p] = prev;
            for (int l = 0; l < pgf_pkg::LANES; l++) begin
                n_pr[p].num[l] = prev.num[l]
                    + (pgf_pkg::t_num'(pgf_pkg::t_p65'(prev.k[32*p +: 32])
                                       * pgf_pkg::t_p65'(prev.mag[l])) << (32 * p));
            end
        end

        // S and R are split as 33+33 and 26+25 bits.
        n_pr[1].d = r_pr[0].d + (pgf_pkg::t_d'(pgf_pkg::t_p59'(r_pr[0].s[65:33])
                                 * pgf_pkg::t_p59'(r_pr[0].r[25:0])) << 33);
        n_pr[2].d = r_pr[1].d + (pgf_pkg::t_d'(pgf_pkg::t_p59'(r_pr[1].s[32:0])
                                 * pgf_pkg::t_p59'(r_pr[1].r[50:26])) << 26);
        n_pr[3].d = r_pr[2].d + (pgf_pkg::t_d'(pgf_pkg::t_p59'(r_pr[2].s[65:33])
                                 * pgf_pkg::t_p59'(r_pr[2].r[50:26])) << 59);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[pgf_pkg::PROD_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < pgf_pkg::PROD_STAGES; j++) begin
                r_pr[j] <= n_pr[j];
            end
        end
    end

    assign o_valid = r_vld[pgf_pkg::PROD_STAGES-1];
    assign o_prod  = r_pr[pgf_pkg::PROD_STAGES-1];

endmodule

[sv/pgf_div.sv]
// Pipelined restoring divider, three lanes sharing one divisor: an overflow
// check stage, then one quotient bit per stage. Uses pgf_pkg.
module pgf_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  pgf_pkg::t_pr  i_prod,
    output logic          o_valid,
    output pgf_pkg::t_res o_res
);

    pgf_pkg::t_dv n_dv [pgf_pkg::DIV_STAGES];
    pgf_pkg::t_dv r_dv [pgf_pkg::DIV_STAGES];
    logic [pgf_pkg::DIV_STAGES-1:0] r_vld;

    always_comb begin
        pgf_pkg::t_dv  prev;
        pgf_pkg::t_dsh sh;
        logic          fit;

        n_dv[0].d    = i_prod.d;
        n_dv[0].neg  = i_prod.neg;
        n_dv[0].zero = i_prod.zero;
        for (int l = 0; l < pgf_pkg::LANES; l++) begin
            // A quotient of 2^64 or more is clipped anyway; otherwise the upper
            // part of the numerator is already a valid partial remainder.
            n_dv[0].rem[l] = pgf_pkg::t_d'(i_prod.num[l][pgf_pkg::NUM_W-1:pgf_pkg::Q_W]);
            n_dv[0].big[l] = (n_dv[0].rem[l] >= i_prod.d);
            n_dv[0].lo[l]  = i_prod.num[l][pgf_pkg::Q_W-1:0];
        end

        for (int j = 1; j < pgf_pkg::DIV_STAGES; j++) begin
            prev    = r_dv[j-1];
            n_dv[j] = prev;
            for (int l = 0; l < pgf_pkg::LANES; l++) begin
                sh  = {prev.rem[l], prev.lo[l][pgf_pkg::Q_W-1]};
                fit = (sh >= {1'b0, prev.d});
                n_dv[j].rem[l] = fit ? pgf_pkg::t_d'(sh - {1'b0, prev.d})
                                     : sh[pgf_pkg::D_W-1:0];
                // Numerator bits leave at the top while quotient bits enter below.
                n_dv[j].lo[l]  = {prev.lo[l][pgf_pkg::Q_W-2:0], fit};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[pgf_pkg::DIV_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < pgf_pkg::DIV_STAGES; j++) begin
                r_dv[j] <= n_dv[j];
            end
        end
    end

    assign o_valid    = r_vld[pgf_pkg::DIV_STAGES-1];
    assign o_res.q    = r_dv[pgf_pkg::DIV_STAGES-1].lo;
    assign o_res.big  = r_dv[pgf_pkg::DIV_STAGES-1].big;
    assign o_res.neg  = r_dv[pgf_pkg::DIV_STAGES-1].neg;
    assign o_res.zero = r_dv[pgf_pkg::DIV_STAGES-1].zero;

endmodule
